// ----- hdl/dwpi_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the dual-wheel incremental PI speed loop.
// No dependencies; used by dwpi_lane, dwpi_merge and the top level.
package dwpi_pkg;

   // request payload layout, lowest bit first
   localparam int REQ_W        = 88;
   localparam int REQ_CNT_L_LO = 0;
   localparam int REQ_CNT_R_LO = 16;
   localparam int REQ_TGT_L_LO = 32;
   localparam int REQ_TGT_R_LO = 56;
   localparam int REQ_STOP_BIT = 80;
   localparam int REQ_CLR_BIT  = 81;

   // response payload width
   localparam int RSP_W   = 128;
   localparam int DRIVE_W = 14;
   localparam int SPEED_W = 24;
   localparam int DIST_W  = 48;
   localparam int MEAN_W  = 47;

   // widest PI sum: accumulator + 43-bit P term + 42-bit I term
   localparam int SUM_W = 45;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [15:0] PROP_GAIN_RST        = 16'd400;
   localparam logic [15:0] INT_GAIN_RST         = 16'd400;
   localparam logic [23:0] SPEED_PER_COUNT_RST  = 24'd220000;
   localparam logic [23:0] METRES_PER_COUNT_RST = 24'd2200;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PROP_GAIN        = 3'd0,
      REG_INT_GAIN         = 3'd1,
      REG_SPEED_PER_COUNT  = 3'd2,
      REG_METRES_PER_COUNT = 3'd3,
      REG_INVERT_LEFT      = 3'd4,
      REG_INVERT_RIGHT     = 3'd5
   } dwpi_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ERR,
      ST_GAIN,
      ST_ACC,
      ST_OUT
   } dwpi_state_type;

   typedef struct packed {
      logic load;   // latch request fields
      logic mul;    // speed and distance products
      logic err;    // saturate speed, error, distance update
      logic gain;   // P and I products
      logic acc;    // accumulate, clamp, store error
      logic emit;   // load the response register
   } dwpi_step_type;

   typedef struct packed {
      logic [15:0] prop_gain;
      logic [15:0] int_gain;
      logic [23:0] speed_per_count;
      logic [23:0] metres_per_count;
   } dwpi_cfg_type;

endpackage

// ----- hdl/dwpi_lane.sv -----
`timescale 1ns / 1ps
// One wheel: count scaling, incremental PI accumulator and odometry distance.
// Depends on dwpi_pkg.
module dwpi_lane #(
   parameter int DRIVE_LIMIT = 7800,
   localparam longint LIM    = longint'(DRIVE_LIMIT) * 65536,
   localparam int ACC_W      = $clog2(LIM + 1) + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dwpi_pkg::dwpi_step_type      step,
   input  dwpi_pkg::dwpi_cfg_type       cfg,
   input  logic                         invert,
   input  logic signed [15:0]           count,
   input  logic signed [23:0]           target,
   input  logic                         stopped,
   input  logic                         clear,
   output logic signed [ACC_W-1:0]      acc,
   output logic signed [23:0]           speed,
   output logic signed [47:0]           distance
);

   localparam int SW = dwpi_pkg::SUM_W;
   localparam logic signed [SW-1:0] LIM_HI = SW'(LIM);
   localparam logic signed [SW-1:0] LIM_LO = -LIM_HI;
   localparam logic signed [40:0] SPD_HI = 41'sd8388607;
   localparam logic signed [40:0] SPD_LO = -41'sd8388608;
   localparam logic signed [48:0] DST_HI = 49'sd140737488355327;
   localparam logic signed [48:0] DST_LO = -49'sd140737488355327;

   logic signed [16:0]       cnt_ff, cnt_in, cnt_ext;
   logic signed [23:0]       target_ff;
   logic                     stopped_ff, clear_ff;
   logic signed [40:0]       pspd_ff, pspd_in, pdst_ff, pdst_in, shifted;
   logic signed [23:0]       speed_ff, speed_in;
   logic signed [24:0]       err_ff, err_in, prev_ff;
   logic signed [25:0]       delta_ff, delta_in;
   logic signed [47:0]       dist_ff, dist_in, dist_base;
   logic signed [48:0]       dsum;
   logic signed [42:0]       pterm_ff, pterm_in;
   logic signed [41:0]       iterm_ff, iterm_in;
   logic signed [SW-1:0]     asum, aval;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   assign cnt_ext = {count[15], count};
   assign cnt_in  = invert ? -cnt_ext : cnt_ext;

   assign pspd_in = cnt_ff * $signed({1'b0, cfg.speed_per_count});
   assign pdst_in = cnt_ff * $signed({1'b0, cfg.metres_per_count});

   // >>> 8 is a floor shift on the signed product
   assign shifted = pspd_ff >>> 8;
   always_comb begin
      priority if (shifted > SPD_HI) begin
         speed_in = 24'sh7FFFFF;
      end else if (shifted < SPD_LO) begin
         speed_in = 24'sh800000;
      end else begin
         speed_in = shifted[23:0];
      end
   end

   assign err_in   = {target_ff[23], target_ff} - {speed_in[23], speed_in};
   assign delta_in = {err_in[24], err_in} - {prev_ff[24], prev_ff};

   assign dist_base = clear_ff ? '0 : dist_ff;
   assign dsum      = {dist_base[47], dist_base} + {{8{pdst_ff[40]}}, pdst_ff};
   always_comb begin
      priority if (dsum > DST_HI) begin
         dist_in = DST_HI[47:0];
      end else if (dsum < DST_LO) begin
         dist_in = DST_LO[47:0];
      end else begin
         dist_in = dsum[47:0];
      end
   end

   assign pterm_in = $signed({1'b0, cfg.prop_gain}) * delta_ff;
   assign iterm_in = $signed({1'b0, cfg.int_gain}) * err_ff;

   assign asum = SW'(acc_ff) + SW'(pterm_ff) + SW'(iterm_ff);
   assign aval = stopped_ff ? '0 : asum;
   always_comb begin
      priority if (aval > LIM_HI) begin
         acc_in = LIM_HI[ACC_W-1:0];
      end else if (aval < LIM_LO) begin
         acc_in = LIM_LO[ACC_W-1:0];
      end else begin
         acc_in = aval[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (step.load) begin
         cnt_ff     <= cnt_in;
         target_ff  <= target;
         stopped_ff <= stopped;
         clear_ff   <= clear;
      end
      if (step.mul) begin
         pspd_ff <= pspd_in;
         pdst_ff <= pdst_in;
      end
      if (step.err) begin
         speed_ff <= speed_in;
         err_ff   <= err_in;
         delta_ff <= delta_in;
      end
      if (step.gain) begin
         pterm_ff <= pterm_in;
         iterm_ff <= iterm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         prev_ff <= '0;
         dist_ff <= '0;
      end else begin
         if (step.err) begin
            dist_ff <= dist_in;
         end
         if (step.acc) begin
            acc_ff  <= acc_in;
            prev_ff <= err_ff;
         end
      end
   end

   assign acc      = acc_ff;
   assign speed    = speed_ff;
   assign distance = dist_ff;

endmodule

// ----- hdl/dwpi_merge.sv -----
`timescale 1ns / 1ps
// Merging stage: truncated drives, mean absolute distance, response register.
// Depends on dwpi_pkg.
module dwpi_merge #(
   parameter int ACC_W = 30
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dwpi_pkg::dwpi_step_type       step,
   input  logic signed [ACC_W-1:0]       acc_left,
   input  logic signed [ACC_W-1:0]       acc_right,
   input  logic signed [23:0]            speed_left,
   input  logic signed [23:0]            speed_right,
   input  logic signed [47:0]            dist_left,
   input  logic signed [47:0]            dist_right,
   input  logic                          rsp_tready,
   output logic                          free,
   output logic                          rsp_tvalid,
   output logic [dwpi_pkg::RSP_W-1:0]    rsp_tdata
);

   localparam logic [ACC_W-1:0] ROUND = ACC_W'(65535);

   logic signed [ACC_W-1:0] bias_l, bias_r, trunc_l, trunc_r, neg_l;
   logic [46:0]             abs_l, abs_r;
   logic [47:0]             abs_sum;
   logic                    valid_ff;
   logic [dwpi_pkg::RSP_W-1:0] data_ff, data_in;

   // truncate toward zero: bias negatives by 2^16-1 before the shift
   assign bias_l  = acc_left  + (acc_left[ACC_W-1]  ? ROUND : '0);
   assign bias_r  = acc_right + (acc_right[ACC_W-1] ? ROUND : '0);
   assign trunc_l = bias_l >>> 16;
   assign trunc_r = bias_r >>> 16;
   assign neg_l   = -trunc_l;

   assign abs_l   = dist_left[47]  ? 47'(-dist_left)  : dist_left[46:0];
   assign abs_r   = dist_right[47] ? 47'(-dist_right) : dist_right[46:0];
   assign abs_sum = {1'b0, abs_l} + {1'b0, abs_r};

   assign data_in = {5'b0, abs_sum[47:1], speed_right, speed_left,
                     trunc_r[13:0], neg_l[13:0]};

   assign free = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (step.emit) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step.emit) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ----- hdl/dual_wheel_incremental_pi_speed_loop.sv -----
`timescale 1ns / 1ps
// Top level: dual-wheel incremental PI speed loop, two wheel lanes and a merge.
// Depends on dwpi_pkg, dwpi_lane, dwpi_merge.
//
//  channel   direction  handshake             payload
//  req_      in         req_tvalid/tready     req_tdata  [87:0]
//  rsp_      out        rsp_tvalid/tready     rsp_tdata  [127:0]
//  csr_      in         csr_valid/ready       csr_index [2:0], csr_data [23:0]
//
// Each request passes through the steps accept, product, error, gain product,
// accumulate, then the merge loads the response register.
// The sequencer holds one request at a time; the next is accepted as soon as the
// response is loaded, even while it still waits on rsp_tready.
// A stalled response holds the sequencer in its last step. Synchronous reset
// clears accumulators, previous errors, distances and registers to defaults.
module dual_wheel_incremental_pi_speed_loop #(
   parameter int DRIVE_LIMIT = 7800
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // count_left[15:0], count_right[31:16], target_left[55:32],
   // target_right[79:56], stopped[80], clear_distance[81], zero pad
   input  logic [dwpi_pkg::REQ_W-1:0]           req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // drive_left[13:0], drive_right[27:14], speed_left[51:28],
   // speed_right[75:52], mean_distance[122:76], zero pad
   output logic [dwpi_pkg::RSP_W-1:0]           rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dwpi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dwpi_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam longint LIM = longint'(DRIVE_LIMIT) * 65536;
   localparam int ACC_W   = $clog2(LIM + 1) + 1;

   dwpi_pkg::dwpi_state_type state_ff, state_in;
   dwpi_pkg::dwpi_step_type  step;
   dwpi_pkg::dwpi_cfg_type   cfg_ff;
   logic                     inv_l_ff, inv_r_ff;
   logic                     free;

   logic signed [ACC_W-1:0]  acc_l, acc_r;
   logic signed [23:0]       spd_l, spd_r;
   logic signed [47:0]       dst_l, dst_r;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain        <= dwpi_pkg::PROP_GAIN_RST;
         cfg_ff.int_gain         <= dwpi_pkg::INT_GAIN_RST;
         cfg_ff.speed_per_count  <= dwpi_pkg::SPEED_PER_COUNT_RST;
         cfg_ff.metres_per_count <= dwpi_pkg::METRES_PER_COUNT_RST;
         inv_l_ff                <= 1'b0;
         inv_r_ff                <= 1'b0;
      end else if (csr_valid) begin
         unique case (dwpi_pkg::dwpi_reg_type'(csr_index))
            dwpi_pkg::REG_PROP_GAIN:        cfg_ff.prop_gain        <= csr_data[15:0];
            dwpi_pkg::REG_INT_GAIN:         cfg_ff.int_gain         <= csr_data[15:0];
            dwpi_pkg::REG_SPEED_PER_COUNT:  cfg_ff.speed_per_count  <= csr_data;
            dwpi_pkg::REG_METRES_PER_COUNT: cfg_ff.metres_per_count <= csr_data;
            dwpi_pkg::REG_INVERT_LEFT:      inv_l_ff                <= csr_data[0];
            dwpi_pkg::REG_INVERT_RIGHT:     inv_r_ff                <= csr_data[0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dwpi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dwpi_pkg::ST_IDLE: if (req_tvalid) state_in = dwpi_pkg::ST_MUL;
         dwpi_pkg::ST_MUL:  state_in = dwpi_pkg::ST_ERR;
         dwpi_pkg::ST_ERR:  state_in = dwpi_pkg::ST_GAIN;
         dwpi_pkg::ST_GAIN: state_in = dwpi_pkg::ST_ACC;
         dwpi_pkg::ST_ACC:  state_in = dwpi_pkg::ST_OUT;
         dwpi_pkg::ST_OUT:  if (free) state_in = dwpi_pkg::ST_IDLE;
         default:           state_in = dwpi_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      step.load  = (state_ff == dwpi_pkg::ST_IDLE) && req_tvalid;
      step.mul   = (state_ff == dwpi_pkg::ST_MUL);
      step.err   = (state_ff == dwpi_pkg::ST_ERR);
      step.gain  = (state_ff == dwpi_pkg::ST_GAIN);
      step.acc   = (state_ff == dwpi_pkg::ST_ACC);
      step.emit  = (state_ff == dwpi_pkg::ST_OUT) && free;
      req_tready = (state_ff == dwpi_pkg::ST_IDLE);
   end

   dwpi_lane #(.DRIVE_LIMIT(DRIVE_LIMIT)) u_lane_left (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .cfg      (cfg_ff),
      .invert   (inv_l_ff),
      .count    (req_tdata[dwpi_pkg::REQ_CNT_L_LO +: 16]),
      .target   (req_tdata[dwpi_pkg::REQ_TGT_L_LO +: 24]),
      .stopped  (req_tdata[dwpi_pkg::REQ_STOP_BIT]),
      .clear    (req_tdata[dwpi_pkg::REQ_CLR_BIT]),
      .acc      (acc_l),
      .speed    (spd_l),
      .distance (dst_l)
   );

   dwpi_lane #(.DRIVE_LIMIT(DRIVE_LIMIT)) u_lane_right (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .cfg      (cfg_ff),
      .invert   (inv_r_ff),
      .count    (req_tdata[dwpi_pkg::REQ_CNT_R_LO +: 16]),
      .target   (req_tdata[dwpi_pkg::REQ_TGT_R_LO +: 24]),
      .stopped  (req_tdata[dwpi_pkg::REQ_STOP_BIT]),
      .clear    (req_tdata[dwpi_pkg::REQ_CLR_BIT]),
      .acc      (acc_r),
      .speed    (spd_r),
      .distance (dst_r)
   );

   dwpi_merge #(.ACC_W(ACC_W)) u_merge (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .acc_left    (acc_l),
      .acc_right   (acc_r),
      .speed_left  (spd_l),
      .speed_right (spd_r),
      .dist_left   (dst_l),
      .dist_right  (dst_r),
      .rsp_tready  (rsp_tready),
      .free        (free),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
